/* rtl/sjis_pkg.sv */
// Shared constants and types for the Shift-JIS to EUC-JP byte stream encoder.
// No dependencies; used by rtl/shift_jis_to_euc_jp_encoder.sv.
`default_nettype none

package sjis_pkg;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 2;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 24;

   // Output byte counts
   localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

   // Reset value of the substitution byte ('?')
   localparam logic [BYTE_W-1:0] DEFAULT_CHAR_RESET = 8'h3F;

   // Half-width katakana prefix
   localparam logic [BYTE_W-1:0] KANA_PREFIX = 8'h8E;

   // Extended-code remap offsets
   localparam logic [WORD_W-1:0] EXT_OFS_ROMAN   = 16'h0B51;
   localparam logic [WORD_W-1:0] EXT_OFS_DIGITS  = 16'h72F6;
   localparam logic [WORD_W-1:0] EXT_OFS_SYMBOL  = 16'h0B5B;
   localparam logic [WORD_W-1:0] EXT_OFS_LOW     = 16'h0D5F;
   localparam logic [WORD_W-1:0] EXT_OFS_MID     = 16'h0D1D;
   localparam logic [WORD_W-1:0] EXT_OFS_HIGH    = 16'h0D1C;
   localparam logic [WORD_W-1:0] EXT_CODE_FA58   = 16'h878A;
   localparam logic [WORD_W-1:0] EXT_CODE_FA59   = 16'h8782;
   localparam logic [WORD_W-1:0] EXT_CODE_FA5A   = 16'h8784;
   localparam logic [WORD_W-1:0] EXT_CODE_FA5B   = 16'h879A;

   // One result word
   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic [BYTE_W-1:0]  second_byte;
      logic [BYTE_W-1:0]  first_byte;
   } rsp_word_type;

endpackage

`default_nettype wire

/* rtl/shift_jis_to_euc_jp_encoder.sv */
// Shift-JIS to EUC-JP byte stream encoder, one source byte per word.
// The result word is registered and valid in the cycle after its completing byte is taken.
// Throughput: one input word per cycle; the input stalls only while a result waits on rsp_tready.
// Reset (synchronous, active high): held lead byte dropped, no result pending,
// substitution byte returns to 0x3F.
// Depends on rtl/sjis_pkg.sv.
`default_nettype none

module shift_jis_to_euc_jp_encoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [sjis_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] in_byte
   input  wire logic                               req_tuser,  // [0] flush
   // response stream
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [sjis_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [7:0] first_byte,
                                                               // [15:8] second_byte,
                                                               // [17:16] byte_count,
                                                               // [23:18] zero
   output      logic                               rsp_tuser,  // [0] substituted
   // configuration
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [sjis_pkg::BYTE_W-1:0]        csr_data    // default_char
);

   localparam int unsigned PAD_W =
      sjis_pkg::RSP_DATA_W - sjis_pkg::COUNT_W - 2 * sjis_pkg::BYTE_W;

   logic                            pending_ff, pending_in;
   logic [sjis_pkg::BYTE_W-1:0]     lead_ff, lead_in;
   logic [sjis_pkg::BYTE_W-1:0]     dflt_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   sjis_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                            rsp_sub_ff, rsp_sub_in;

   logic                            req_fire;
   logic                            rsp_fire;
   logic                            produce;
   logic [sjis_pkg::BYTE_W-1:0]     in_byte;
   logic                            flush;
   logic                            is_lead;

   logic [sjis_pkg::WORD_W-1:0]     ext_word;
   logic [sjis_pkg::WORD_W-1:0]     map_word;
   logic [sjis_pkg::BYTE_W-1:0]     m_lead;
   logic [sjis_pkg::BYTE_W-1:0]     m_trail;
   logic [sjis_pkg::BYTE_W-1:0]     lead_base;
   logic [sjis_pkg::BYTE_W-1:0]     row_ofs;
   logic [sjis_pkg::BYTE_W-1:0]     jis_first;
   logic [sjis_pkg::BYTE_W-1:0]     jis_second;
   sjis_pkg::rsp_word_type          conv_word;
   logic                            conv_sub;

   assign in_byte   = req_tdata[sjis_pkg::BYTE_W-1:0];
   assign flush     = req_tuser;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_valid_ff && rsp_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign is_lead = (in_byte inside {[8'h81:8'h9F], [8'hE0:8'hFC]});

   // Vendor extended codes move to the NEC-selected area (ED/EE leads) or to NEC row 13 (87 lead)
   assign ext_word = {lead_ff, in_byte};
   always_comb begin
      map_word = ext_word;
      if ((lead_ff inside {[8'hFA:8'hFC]}) && (in_byte >= 8'h40)) begin
         if (ext_word inside {[16'hFA40:16'hFA49]}) begin
            map_word = ext_word - sjis_pkg::EXT_OFS_ROMAN;
         end else if (ext_word inside {[16'hFA4A:16'hFA53]}) begin
            map_word = ext_word - sjis_pkg::EXT_OFS_DIGITS;
         end else if (ext_word inside {[16'hFA54:16'hFA57]}) begin
            map_word = ext_word - sjis_pkg::EXT_OFS_SYMBOL;
         end else if (ext_word == 16'hFA58) begin
            map_word = sjis_pkg::EXT_CODE_FA58;
         end else if (ext_word == 16'hFA59) begin
            map_word = sjis_pkg::EXT_CODE_FA59;
         end else if (ext_word == 16'hFA5A) begin
            map_word = sjis_pkg::EXT_CODE_FA5A;
         end else if (ext_word == 16'hFA5B) begin
            map_word = sjis_pkg::EXT_CODE_FA5B;
         end else if (ext_word inside {[16'hFA5C:16'hFC4B]}) begin
            if (in_byte < 8'h5C) begin
               map_word = ext_word - sjis_pkg::EXT_OFS_LOW;
            end else if (in_byte inside {[8'h80:8'h9B]}) begin
               map_word = ext_word - sjis_pkg::EXT_OFS_MID;
            end else begin
               map_word = ext_word - sjis_pkg::EXT_OFS_HIGH;
            end
         end
      end
   end

   assign m_lead  = map_word[sjis_pkg::WORD_W-1:sjis_pkg::BYTE_W];
   assign m_trail = map_word[sjis_pkg::BYTE_W-1:0];

   // Double-byte to EUC-JP row/cell arithmetic, wrapping mod 256
   always_comb begin
      if (m_lead <= 8'h9F) begin
         lead_base = m_lead - 8'h81;
         row_ofs   = (m_trail <= 8'h9E) ? 8'hA1 : 8'hA2;
      end else begin
         lead_base = m_lead - 8'hE0;
         row_ofs   = (m_trail <= 8'h9E) ? 8'hDF : 8'hE0;
      end
      jis_first = {lead_base[sjis_pkg::BYTE_W-2:0], 1'b0} + row_ofs;
      if (m_trail inside {[8'h40:8'h7E]}) begin
         jis_second = m_trail + 8'h61;
      end else if (m_trail inside {[8'h80:8'h9E]}) begin
         jis_second = m_trail + 8'h60;
      end else begin
         jis_second = m_trail + 8'h02;
      end
   end

   // Result selection for the accepted byte
   always_comb begin
      conv_sub = 1'b0;
      if (!pending_ff) begin
         if (in_byte inside {[8'hA1:8'hDF]}) begin
            conv_word = '{byte_count: sjis_pkg::COUNT_TWO, second_byte: in_byte,
                          first_byte: sjis_pkg::KANA_PREFIX};
         end else begin
            conv_word = '{byte_count: sjis_pkg::COUNT_ONE, second_byte: 8'h00,
                          first_byte: in_byte};
         end
      end else if (m_lead <= 8'hEF) begin
         conv_word = '{byte_count: sjis_pkg::COUNT_TWO, second_byte: jis_second,
                       first_byte: jis_first};
      end else if (m_lead >= 8'hFA) begin
         conv_word = '{byte_count: sjis_pkg::COUNT_ONE, second_byte: 8'h00,
                       first_byte: dflt_ff};
         conv_sub  = 1'b1;
      end else begin
         conv_word = '{byte_count: sjis_pkg::COUNT_TWO, second_byte: m_trail,
                       first_byte: m_lead};
      end
   end

   assign produce = req_fire && !flush && (pending_ff || !is_lead);

   // Lead byte holding
   always_comb begin
      pending_in = pending_ff;
      lead_in    = lead_ff;
      if (req_fire) begin
         if (flush || pending_ff) begin
            pending_in = 1'b0;
            lead_in    = '0;
         end else if (is_lead) begin
            pending_in = 1'b1;
            lead_in    = in_byte;
         end
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_sub_in   = rsp_sub_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = conv_word;
         rsp_sub_in   = conv_sub;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         lead_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dflt_ff      <= sjis_pkg::DEFAULT_CHAR_RESET;
      end else begin
         pending_ff   <= pending_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            dflt_ff <= csr_data;
         end
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_sub_ff  <= rsp_sub_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_word_ff};
   assign rsp_tuser  = rsp_sub_ff;

   // A trail byte or flush always leaves no lead held
   a_trail_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && (flush || pending_ff) |=> !pending_ff && (lead_ff == '0))
      else $error("lead byte still held after trail or flush");

   // A held lead is always a legal Shift-JIS lead byte
   a_lead_legal: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> ((lead_ff >= 8'h81) && (lead_ff <= 8'h9F)) ||
                     ((lead_ff >= 8'hE0) && (lead_ff <= 8'hFC)))
      else $error("held lead byte out of lead range");

   // A substituted result is a single byte
   a_sub_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sub_ff |->
         (rsp_word_ff.byte_count == sjis_pkg::COUNT_ONE) &&
         (rsp_word_ff.second_byte == 8'h00))
      else $error("substituted result carries a second byte");

   // Byte count is one or two on every result
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.byte_count == sjis_pkg::COUNT_ONE) ||
                       (rsp_word_ff.byte_count == sjis_pkg::COUNT_TWO))
      else $error("byte count out of range");

endmodule

`default_nettype wire
